// File: sv/mtr_pkg.sv
// shared types and constants for the mosaic tile rectangle calculator
`timescale 1ns / 1ps

package mtr_pkg;

   localparam int CNT_W           = 12;
   localparam int FX_W            = 17;
   // columns and rows reach ceil(sqrt(4095)) = 64
   localparam int COL_W           = 7;
   // grid numerators and twice the column count
   localparam int NUM_W           = COL_W + 1;
   localparam int MAX_STREAMS_DEF = 1024;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int QUEUE_DEPTH     = 2;

   typedef struct packed {
      logic             layout_ok;
      logic             single;
      logic             pair;
      logic [CNT_W-1:0] tile_count;
      logic [COL_W-1:0] cols;
      logic [COL_W-1:0] rows;
      logic [COL_W-1:0] last;
   } layout_type;

   typedef struct packed {
      logic             layout_ok;
      logic             index_ok;
      logic             single;
      logic             pair;
      logic             odd;
      logic [CNT_W-1:0] tile_count;
      logic [COL_W-1:0] row;
      logic [COL_W-1:0] col;
   } item_type;

endpackage

// File: sv/mtr_layout.sv
// stream count register and per-count grid geometry sequencer
`timescale 1ns / 1ps

module mtr_layout #(
   parameter int MAX_STREAMS = mtr_pkg::MAX_STREAMS_DEF,
   parameter int FRAC_BITS   = mtr_pkg::FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [mtr_pkg::CNT_W-1:0]              csr_wr_data,
   output mtr_pkg::layout_type                    layout,
   output logic [FRAC_BITS+mtr_pkg::NUM_W-1:0]    m_col,
   output logic [FRAC_BITS+mtr_pkg::NUM_W-1:0]    m_row,
   output logic                                   busy
);
   import mtr_pkg::*;

   localparam int RCP_W     = FRAC_BITS + NUM_W;
   localparam int DIV_STEPS = RCP_W + 1;
   localparam int STEP_W    = $clog2(DIV_STEPS);
   localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_STREAMS);

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_ROOT    = 5'b00010,
      ST_ROWS    = 5'b00100,
      ST_RCP_COL = 5'b01000,
      ST_RCP_ROW = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [COL_W-1:0]   cols_ff, cols_in;
   logic [COL_W-1:0]   rows_ff, rows_in;
   logic [COL_W-1:0]   last_ff, last_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [NUM_W-1:0]   div_rem_ff, div_rem_in;
   logic [RCP_W-1:0]   div_quo_ff, div_quo_in;
   logic [RCP_W-1:0]   m_col_ff, m_col_in;
   logic [RCP_W-1:0]   m_row_ff, m_row_in;

   logic               grid;
   logic [2*COL_W-1:0] sq;
   logic [NUM_W-1:0]   div_d;
   logic [NUM_W-1:0]   div_shift;
   logic               div_ge;
   logic [RCP_W-1:0]   div_quo_next;

   assign grid = (n_ff >= CNT_W'(3)) && (n_ff <= MAX_N);
   assign sq   = (2*COL_W)'(cols_ff) * (2*COL_W)'(cols_ff);

   // shared restoring divider computes floor(2^RCP_W / d), one bit a cycle
   assign div_d        = (state_ff == ST_RCP_COL) ? NUM_W'(cols_ff) : NUM_W'(rows_ff);
   assign div_shift    = {div_rem_ff[NUM_W-2:0], (step_ff == '0)};
   assign div_ge       = div_shift >= div_d;
   assign div_quo_next = {div_quo_ff[RCP_W-2:0], div_ge};

   always_comb begin
      state_in   = state_ff;
      n_in       = n_ff;
      cols_in    = cols_ff;
      rows_in    = rows_ff;
      last_in    = last_ff;
      rem_in     = rem_ff;
      step_in    = step_ff;
      div_rem_in = div_rem_ff;
      div_quo_in = div_quo_ff;
      m_col_in   = m_col_ff;
      m_row_in   = m_row_ff;
      case (state_ff)
         ST_IDLE: begin
         end
         ST_ROOT: begin
            if (!grid) begin
               state_in = ST_IDLE;
            end else if (sq < (2*COL_W)'(n_ff)) begin
               cols_in = COL_W'(cols_ff + COL_W'(1));
            end else begin
               state_in = ST_ROWS;
               rem_in   = n_ff;
               rows_in  = '0;
            end
         end
         ST_ROWS: begin
            if (rem_ff >= CNT_W'(cols_ff)) begin
               rem_in  = rem_ff - CNT_W'(cols_ff);
               rows_in = COL_W'(rows_ff + COL_W'(1));
            end else begin
               last_in = COL_W'(rem_ff);
               if (rem_ff != '0) begin
                  rows_in = COL_W'(rows_ff + COL_W'(1));
               end
               state_in   = ST_RCP_COL;
               step_in    = '0;
               div_rem_in = '0;
            end
         end
         ST_RCP_COL, ST_RCP_ROW: begin
            div_rem_in = div_ge ? div_shift - div_d : div_shift;
            div_quo_in = div_quo_next;
            step_in    = STEP_W'(step_ff + STEP_W'(1));
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               step_in    = '0;
               div_rem_in = '0;
               if (state_ff == ST_RCP_COL) begin
                  m_col_in = div_quo_next;
                  state_in = ST_RCP_ROW;
               end else begin
                  m_row_in = div_quo_next;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // a register write always restarts the geometry pass
      if (csr_wr_en) begin
         n_in     = csr_wr_data;
         cols_in  = COL_W'(1);
         state_in = ST_ROOT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         n_ff     <= CNT_W'(1);
      end else begin
         state_ff <= state_in;
         n_ff     <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      cols_ff    <= cols_in;
      rows_ff    <= rows_in;
      last_ff    <= last_in;
      rem_ff     <= rem_in;
      step_ff    <= step_in;
      div_rem_ff <= div_rem_in;
      div_quo_ff <= div_quo_in;
      m_col_ff   <= m_col_in;
      m_row_ff   <= m_row_in;
   end

   always_comb begin
      layout.layout_ok  = n_ff <= MAX_N;
      layout.single     = n_ff < CNT_W'(2);
      layout.pair       = n_ff == CNT_W'(2);
      layout.tile_count = (n_ff > MAX_N) ? '0 : ((n_ff < CNT_W'(2)) ? CNT_W'(1) : n_ff);
      layout.cols       = cols_ff;
      layout.rows       = rows_ff;
      layout.last       = last_ff;
   end

   assign m_col = m_col_ff;
   assign m_row = m_row_ff;
   assign busy  = state_ff != ST_IDLE;

`ifndef SYNTHESIS
   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> busy)
      else $error("geometry pass not started after register write");

   a_root_exact: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) && grid |->
         (sq >= (2*COL_W)'(n_ff)) &&
         (((2*COL_W)'(cols_ff - COL_W'(1)) * (2*COL_W)'(cols_ff - COL_W'(1)))
            < (2*COL_W)'(n_ff)))
      else $error("column count is not the ceiling square root");
`endif

endmodule

// File: sv/mtr_front.sv
// front end: takes requests, checks the index and splits it into row and column
`timescale 1ns / 1ps

module mtr_front #(
   parameter int FRAC_BITS = mtr_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic [mtr_pkg::CNT_W-1:0]           tile_index,
   input  mtr_pkg::layout_type                 layout,
   input  logic [FRAC_BITS+mtr_pkg::NUM_W-1:0] m_col,
   output logic                                push,
   output mtr_pkg::item_type                   item
);
   import mtr_pkg::*;

   localparam int RCP_W  = FRAC_BITS + NUM_W;
   localparam int PROD_W = CNT_W + RCP_W;

   logic              v1_ff, v1_in;
   logic [CNT_W-1:0]  idx1_ff, idx1_in;
   logic [CNT_W-1:0]  q1_ff, q1_in;
   logic              iv1_ff, iv1_in;

   logic [PROD_W-1:0] idx_prod;
   logic [CNT_W-1:0]  qc;
   logic [CNT_W-1:0]  rem;
   logic              fix;

   // quotient estimate by reciprocal, low by at most one
   assign idx_prod = PROD_W'(tile_index) * PROD_W'(m_col);
   assign v1_in    = accept;
   assign idx1_in  = tile_index;
   assign q1_in    = idx_prod[PROD_W-1:RCP_W];
   assign iv1_in   = layout.layout_ok && (tile_index < layout.tile_count);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
      end
   end

   always_ff @(posedge clock) begin
      idx1_ff <= idx1_in;
      q1_ff   <= q1_in;
      iv1_ff  <= iv1_in;
   end

   assign qc  = CNT_W'(q1_ff * CNT_W'(layout.cols));
   assign rem = idx1_ff - qc;
   assign fix = rem >= CNT_W'(layout.cols);

   always_comb begin
      item.layout_ok  = layout.layout_ok;
      item.index_ok   = iv1_ff;
      item.single     = layout.single;
      item.pair       = layout.pair;
      item.odd        = idx1_ff[0];
      item.tile_count = layout.tile_count;
      item.row        = fix ? COL_W'(q1_ff + CNT_W'(1)) : COL_W'(q1_ff);
      item.col        = fix ? COL_W'(rem - CNT_W'(layout.cols)) : COL_W'(rem);
   end

   assign push = v1_ff;

`ifndef SYNTHESIS
   a_split_exact: assert property (@(posedge clock) disable iff (reset)
      push && item.index_ok && !item.single && !item.pair |->
         (item.col < layout.cols) &&
         (CNT_W'(CNT_W'(item.row) * CNT_W'(layout.cols)) + CNT_W'(item.col) == idx1_ff))
      else $error("row and column do not recombine to the tile index");
`endif

endmodule

// File: sv/mtr_queue.sv
// short word queue between front end and back end
`timescale 1ns / 1ps

module mtr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mtr_pkg::item_type push_item,
   input  logic              pop,
   output logic              valid,
   output mtr_pkg::item_type head
);
   import mtr_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_Q = $clog2(QUEUE_DEPTH + 1);

   item_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_Q-1:0]  count_ff, count_in;
   logic              full;
   logic              do_pop;

   assign full   = count_ff == CNT_Q'(QUEUE_DEPTH);
   assign valid  = count_ff != '0;
   assign do_pop = pop && valid;
   assign head   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                             : PTR_W'(wr_ptr_ff + PTR_W'(1));
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                             : PTR_W'(rd_ptr_ff + PTR_W'(1));
      end
      if (push && !do_pop) begin
         count_in = CNT_Q'(count_ff + CNT_Q'(1));
      end else if (!push && do_pop) begin
         count_in = CNT_Q'(count_ff - CNT_Q'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || do_pop))
      else $error("word pushed into a full queue");
`endif

endmodule

// File: sv/mtr_back.sv
// back end: turns row and column into fixed point tile edges and sizes
`timescale 1ns / 1ps

module mtr_back #(
   parameter int FRAC_BITS = mtr_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                valid,
   input  mtr_pkg::item_type                   item,
   input  mtr_pkg::layout_type                 layout,
   input  logic [FRAC_BITS+mtr_pkg::NUM_W-1:0] m_col,
   input  logic [FRAC_BITS+mtr_pkg::NUM_W-1:0] m_row,
   output logic                                strobe,
   output logic                                layout_valid,
   output logic [mtr_pkg::CNT_W-1:0]           tile_count,
   output logic                                index_valid,
   output logic [mtr_pkg::FX_W-1:0]            left_x,
   output logic [mtr_pkg::FX_W-1:0]            top_y,
   output logic [mtr_pkg::FX_W-1:0]            tile_width,
   output logic [mtr_pkg::FX_W-1:0]            tile_height
);
   import mtr_pkg::*;

   localparam int RCP_W  = FRAC_BITS + NUM_W;
   localparam int FR_W   = FRAC_BITS + 1;
   localparam int PROD_W = NUM_W + RCP_W;
   localparam int CHK_W  = FR_W + 1 + NUM_W;
   localparam logic [FR_W-1:0] ONE_FX     = FR_W'(1) << FRAC_BITS;
   localparam logic [FR_W-1:0] HALF_FX    = ONE_FX >> 1;
   localparam logic [FR_W-1:0] QUARTER_FX = ONE_FX >> 2;

   // first stage: numerator, divisor and reciprocal product
   logic              short_row;
   logic [NUM_W-1:0]  ax, dx, ay, dy;
   logic [RCP_W-1:0]  mx;
   logic [PROD_W-1:0] prod_x, prod_y;

   logic              vb_ff;
   item_type          itb_ff;
   logic [FR_W-1:0]   qx_ff, qy_ff;
   logic [NUM_W-1:0]  ax_ff, dx_ff, ay_ff, dy_ff;

   logic [CHK_W-1:0]  x_chk, x_lim, y_chk, y_lim;
   logic [FR_W-1:0]   x_grid, y_grid;
   logic [FR_W-1:0]   x_sel, y_sel, w_sel, h_sel;

   logic              strobe_ff;
   logic              lv_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              iv_ff;
   logic [FX_W-1:0]   x_ff, y_ff, w_ff, h_ff;

   // a short last row is centered: left = (cols - last + 2c) / (2 cols)
   assign short_row = (NUM_W'(item.row) + NUM_W'(1) == NUM_W'(layout.rows)) &&
                      (layout.last != '0);

   always_comb begin
      if (short_row) begin
         ax = NUM_W'(layout.cols) - NUM_W'(layout.last) + (NUM_W'(item.col) << 1);
         dx = NUM_W'(layout.cols) << 1;
         mx = m_col >> 1;
      end else begin
         ax = NUM_W'(item.col);
         dx = NUM_W'(layout.cols);
         mx = m_col;
      end
      ay = NUM_W'(item.row);
      dy = NUM_W'(layout.rows);
   end

   assign prod_x = PROD_W'(ax) * PROD_W'(mx);
   assign prod_y = PROD_W'(ay) * PROD_W'(m_row);

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else begin
         vb_ff <= valid;
      end
   end

   always_ff @(posedge clock) begin
      itb_ff <= item;
      qx_ff  <= prod_x[NUM_W+FR_W-1:NUM_W];
      qy_ff  <= prod_y[NUM_W+FR_W-1:NUM_W];
      ax_ff  <= ax;
      dx_ff  <= dx;
      ay_ff  <= ay;
      dy_ff  <= dy;
   end

   // second stage: bump the estimate when one more divisor still fits
   assign x_chk  = (CHK_W'(qx_ff) + CHK_W'(1)) * CHK_W'(dx_ff);
   assign x_lim  = CHK_W'(ax_ff) << FRAC_BITS;
   assign y_chk  = (CHK_W'(qy_ff) + CHK_W'(1)) * CHK_W'(dy_ff);
   assign y_lim  = CHK_W'(ay_ff) << FRAC_BITS;
   assign x_grid = (x_chk <= x_lim) ? FR_W'(qx_ff + FR_W'(1)) : qx_ff;
   assign y_grid = (y_chk <= y_lim) ? FR_W'(qy_ff + FR_W'(1)) : qy_ff;

   always_comb begin
      x_sel = '0;
      y_sel = '0;
      w_sel = '0;
      h_sel = '0;
      if (itb_ff.index_ok) begin
         if (itb_ff.single) begin
            w_sel = ONE_FX;
            h_sel = ONE_FX;
         end else if (itb_ff.pair) begin
            x_sel = itb_ff.odd ? HALF_FX : '0;
            y_sel = QUARTER_FX;
            w_sel = HALF_FX;
            h_sel = HALF_FX;
         end else begin
            x_sel = x_grid;
            y_sel = y_grid;
            w_sel = FR_W'(m_col >> NUM_W);
            h_sel = FR_W'(m_row >> NUM_W);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      lv_ff  <= itb_ff.layout_ok;
      cnt_ff <= itb_ff.tile_count;
      iv_ff  <= itb_ff.index_ok;
      x_ff   <= FX_W'(x_sel);
      y_ff   <= FX_W'(y_sel);
      w_ff   <= FX_W'(w_sel);
      h_ff   <= FX_W'(h_sel);
   end

   assign strobe       = strobe_ff;
   assign layout_valid = lv_ff;
   assign tile_count   = cnt_ff;
   assign index_valid  = iv_ff;
   assign left_x       = x_ff;
   assign top_y        = y_ff;
   assign tile_width   = w_ff;
   assign tile_height  = h_ff;

endmodule

// File: sv/mosaic_tile_rect_calc.sv
// top level of the mosaic tile rectangle calculator
// Usage:
//  - csr_wr_en / csr_wr_data write the stream count (reset value 1). After a
//    write, busy stays high while the grid geometry is derived: column count
//    by a ceiling square root search, row count by repeated subtraction and
//    two reciprocals by a shared bit-serial divider. Counts below 3 or above
//    MAX_STREAMS skip it.
//  - a request word (req_tile_index) is taken at a clock edge with start high
//    and busy low; a new word can follow every cycle while busy stays low.
//  - each word gives one result word, shown for one cycle with rsp_strobe,
//    in request order, after the front end register, the queue and the back end stages.
//  - the receiver cannot stall; a short queue sits between the index
//    splitting front end and the fixed point back end.
//  - synchronous reset drops all words in flight and returns the stream
//    count to 1 with busy low.
`timescale 1ns / 1ps

module mosaic_tile_rect_calc #(
   parameter int MAX_STREAMS = mtr_pkg::MAX_STREAMS_DEF,
   parameter int FRAC_BITS   = mtr_pkg::FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [mtr_pkg::CNT_W-1:0]  req_tile_index,
   input  logic                       csr_wr_en,
   input  logic [mtr_pkg::CNT_W-1:0]  csr_wr_data,
   output logic                       rsp_strobe,
   output logic                       rsp_layout_valid,
   output logic [mtr_pkg::CNT_W-1:0]  rsp_tile_count,
   output logic                       rsp_index_valid,
   output logic [mtr_pkg::FX_W-1:0]   rsp_left_x,
   output logic [mtr_pkg::FX_W-1:0]   rsp_top_y,
   output logic [mtr_pkg::FX_W-1:0]   rsp_tile_width,
   output logic [mtr_pkg::FX_W-1:0]   rsp_tile_height
);
   import mtr_pkg::*;

   localparam int RCP_W = FRAC_BITS + NUM_W;

   layout_type       layout;
   logic [RCP_W-1:0] m_col;
   logic [RCP_W-1:0] m_row;
   logic             layout_busy;
   logic             accept;
   logic             push;
   item_type         push_item;
   logic             q_valid;
   item_type         q_head;

   assign busy   = layout_busy;
   assign accept = start && !layout_busy;

   mtr_layout #(
      .MAX_STREAMS (MAX_STREAMS),
      .FRAC_BITS   (FRAC_BITS)
   ) u_layout (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .layout      (layout),
      .m_col       (m_col),
      .m_row       (m_row),
      .busy        (layout_busy)
   );

   mtr_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .tile_index (req_tile_index),
      .layout     (layout),
      .m_col      (m_col),
      .push       (push),
      .item       (push_item)
   );

   mtr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (q_valid),
      .valid     (q_valid),
      .head      (q_head)
   );

   mtr_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .valid        (q_valid),
      .item         (q_head),
      .layout       (layout),
      .m_col        (m_col),
      .m_row        (m_row),
      .strobe       (rsp_strobe),
      .layout_valid (rsp_layout_valid),
      .tile_count   (rsp_tile_count),
      .index_valid  (rsp_index_valid),
      .left_x       (rsp_left_x),
      .top_y        (rsp_top_y),
      .tile_width   (rsp_tile_width),
      .tile_height  (rsp_tile_height)
   );

`ifndef SYNTHESIS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##4 rsp_strobe)
      else $error("result word missing four cycles after request");

   a_zero_rect: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_index_valid |->
         (rsp_left_x == '0) && (rsp_top_y == '0) &&
         (rsp_tile_width == '0) && (rsp_tile_height == '0))
      else $error("rectangle not cleared for an invalid index");
`endif

endmodule

// File: tb/sv/tb.sv
// testbench for the mosaic tile rectangle calculator: directed and random tile queries
`timescale 1ns / 1ps

module tb;
   import mtr_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASES      = 40;
   localparam int PHASE_WORDS = 50;

   typedef struct packed {
      logic             layout_valid;
      logic [CNT_W-1:0] tile_count;
      logic             index_valid;
      logic [FX_W-1:0]  left_x;
      logic [FX_W-1:0]  top_y;
      logic [FX_W-1:0]  tile_width;
      logic [FX_W-1:0]  tile_height;
   } tile_rect_type;

   typedef struct {
      logic [CNT_W-1:0] tile_index;
      bit               drain;   // wait for all results before sending this word
   } tile_query_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic [CNT_W-1:0] req_tile_index = '0;
   logic             csr_wr_en = 1'b0;
   logic [CNT_W-1:0] csr_wr_data = '0;
   logic             busy;
   logic             rsp_strobe;
   logic             rsp_layout_valid;
   logic [CNT_W-1:0] rsp_tile_count;
   logic             rsp_index_valid;
   logic [FX_W-1:0]  rsp_left_x;
   logic [FX_W-1:0]  rsp_top_y;
   logic [FX_W-1:0]  rsp_tile_width;
   logic [FX_W-1:0]  rsp_tile_height;

   tile_query_type query_q[$];
   tile_rect_type  rect_q[$];
   tile_rect_type  want_rect;
   int unsigned stream_cfg = 1;
   int unsigned idle_pct = 34;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;

   mosaic_tile_rect_calc uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_tile_index   (req_tile_index),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_layout_valid (rsp_layout_valid),
      .rsp_tile_count   (rsp_tile_count),
      .rsp_index_valid  (rsp_index_valid),
      .rsp_left_x       (rsp_left_x),
      .rsp_top_y        (rsp_top_y),
      .rsp_tile_width   (rsp_tile_width),
      .rsp_tile_height  (rsp_tile_height)
   );

   always #2 clock = ~clock;

   function automatic int unsigned grid_cols(int unsigned count);
      int unsigned c;
      c = 1;
      while (c * c < count) c++;
      return c;
   endfunction

   function automatic tile_rect_type predict_rect(int unsigned count, int unsigned idx);
      tile_rect_type r;
      int unsigned one, cols, rows, last, row, col, x, y, w, h;
      r = '0;
      one = 1 << FRAC_BITS_DEF;
      x = 0;
      y = 0;
      w = 0;
      h = 0;
      if (count <= MAX_STREAMS_DEF) begin
         r.layout_valid = 1'b1;
         r.tile_count = CNT_W'((count < 2) ? 1 : count);
         if (idx < 32'(r.tile_count)) begin
            r.index_valid = 1'b1;
            if (count < 2) begin
               w = one;
               h = one;
            end else if (count == 2) begin
               x = (idx == 0) ? 0 : one / 2;
               y = one / 4;
               w = one / 2;
               h = one / 2;
            end else begin
               cols = grid_cols(count);
               last = count % cols;
               rows = count / cols + ((last != 0) ? 1 : 0);
               row = idx / cols;
               col = idx % cols;
               w = one / cols;
               h = one / rows;
               y = (row * one) / rows;
               // short last row sits centered
               if (row + 1 == rows && last != 0)
                  x = ((cols - last + 2 * col) * one) / (2 * cols);
               else
                  x = (col * one) / cols;
            end
         end
      end
      r.left_x = FX_W'(x);
      r.top_y = FX_W'(y);
      r.tile_width = FX_W'(w);
      r.tile_height = FX_W'(h);
      return r;
   endfunction

   task automatic queue_query(int unsigned idx, bit drain);
      tile_query_type q;
      q.tile_index = CNT_W'(idx);
      q.drain = drain;
      query_q.push_back(q);
   endtask

   // settled check at the falling edge, away from the driver and monitor
   task automatic wait_quiet();
      @(negedge clock);
      while (query_q.size() != 0 || start || busy || rect_q.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_stream_count(int unsigned value);
      wait_quiet();
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= CNT_W'(value);
      stream_cfg = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   function automatic int unsigned pick_count();
      int unsigned r, k;
      r = $urandom_range(0, 99);
      if (r < 5) return $urandom_range(0, 2);
      if (r < 10) return $urandom_range(MAX_STREAMS_DEF + 1, 4095);
      if (r < 13) return MAX_STREAMS_DEF;
      if (r < 22) begin
         k = $urandom_range(2, 32);
         return k * k + $urandom_range(0, 2) - 1;
      end
      return $urandom_range(3, MAX_STREAMS_DEF);
   endfunction

   function automatic int unsigned pick_index(int unsigned count);
      int unsigned r, tiles, cols;
      r = $urandom_range(0, 99);
      if (count > MAX_STREAMS_DEF || r < 10) return $urandom_range(0, 4095);
      tiles = (count < 2) ? 1 : count;
      if (r < 15) return tiles;
      // lean on the last row where it may be short
      if (r < 40 && count >= 3) begin
         cols = grid_cols(count);
         return $urandom_range(((tiles - 1) / cols) * cols, tiles - 1);
      end
      return $urandom_range(0, tiles - 1);
   endfunction

   // driver: prediction is taken at the accepting edge
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy)
            rect_q.push_back(predict_rect(stream_cfg, 32'(req_tile_index)));
         if (start && busy) begin
            // hold the word until taken
         end else if (query_q.size() != 0 && $urandom_range(0, 99) >= idle_pct &&
                      !(query_q[0].drain && rect_q.size() != 0)) begin
            start <= 1'b1;
            req_tile_index <= query_q[0].tile_index;
            void'(query_q.pop_front());
         end else begin
            start <= 1'b0;
         end
      end
   end

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (rect_q.size() == 0) begin
            $display("%0t: result word with none expected", $time);
            error_count++;
         end else begin
            want_rect = rect_q.pop_front();
            check_field("layout_valid", 32'(want_rect.layout_valid),
                        32'(rsp_layout_valid));
            check_field("tile_count", 32'(want_rect.tile_count), 32'(rsp_tile_count));
            check_field("index_valid", 32'(want_rect.index_valid),
                        32'(rsp_index_valid));
            check_field("left_x", 32'(want_rect.left_x), 32'(rsp_left_x));
            check_field("top_y", 32'(want_rect.top_y), 32'(rsp_top_y));
            check_field("tile_width", 32'(want_rect.tile_width), 32'(rsp_tile_width));
            check_field("tile_height", 32'(want_rect.tile_height),
                        32'(rsp_tile_height));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   initial begin
      int unsigned count, drain_at;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset count gives the single full-frame tile
      queue_query(0, 0);
      queue_query(1, 0);
      queue_query(4095, 0);
      write_stream_count(2);
      queue_query(0, 1);
      queue_query(1, 0);
      queue_query(2, 0);
      write_stream_count(0);
      queue_query(0, 0);
      queue_query(1, 0);
      write_stream_count(4095);
      queue_query(0, 0);
      queue_query(4095, 0);
      write_stream_count(MAX_STREAMS_DEF + 1);
      queue_query(0, 0);
      write_stream_count(MAX_STREAMS_DEF);
      queue_query(0, 0);
      queue_query(MAX_STREAMS_DEF - 1, 0);
      queue_query(MAX_STREAMS_DEF, 0);
      write_stream_count(3);
      queue_query(0, 0);
      queue_query(1, 0);
      queue_query(2, 0);
      queue_query(3, 0);
      write_stream_count(7);
      queue_query(6, 0);
      queue_query(2, 0);

      for (int p = 0; p < PHASES; p++) begin
         count = pick_count();
         write_stream_count(count);
         idle_pct = (p < PHASES / 3) ? 34 : (p < 2 * PHASES / 3) ? 51 : 0;
         drain_at = $urandom_range(0, PHASE_WORDS - 1);
         for (int i = 0; i < PHASE_WORDS; i++)
            queue_query(pick_index(count), i == drain_at);
      end

      wait_quiet();
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule

// File: mosaic_tile_rect_calc.f
sv/mtr_pkg.sv
sv/mtr_layout.sv
sv/mtr_front.sv
sv/mtr_queue.sv
sv/mtr_back.sv
sv/mosaic_tile_rect_calc.sv
tb/sv/tb.sv
